[src/bacs_pkg.sv]
`default_nettype none

package bacs_pkg;

    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;
    localparam int INDEX_WIDTH = 14;
    localparam int QUEUE_DEPTH = 4;
    localparam int COUNT_WIDTH = 3;

    localparam logic [7:0] FULL_MASK = 8'hff;

    typedef enum logic [1:0] {
        REG_SRC_BIT_OFFSET = 2'd0,
        REG_DST_BIT_OFFSET = 2'd1,
        REG_BIT_LENGTH     = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0]             dst_byte;
        logic [7:0]             write_mask;
        logic [INDEX_WIDTH-1:0] dst_index;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

[src/bacs_align.sv]
`default_nettype none

module bacs_align #(
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic [7:0]              src_byte,
    input  wire logic [2:0]              src_bit_offset,
    input  wire logic [2:0]              dst_bit_offset,
    input  wire logic [LENGTH_WIDTH-1:0] bit_length,
    output bacs_pkg::push_t              push
);

    logic                               in_transfer_reg;
    logic                               in_transfer_next;
    logic [6:0]                         carry_bits_reg;
    logic [6:0]                         carry_bits_next;
    logic [2:0]                         carry_count_reg;
    logic [2:0]                         carry_count_next;
    logic [LENGTH_WIDTH-1:0]            bits_left_reg;
    logic [LENGTH_WIDTH-1:0]            bits_left_next;
    logic [bacs_pkg::INDEX_WIDTH-1:0]   out_count_reg;
    logic [bacs_pkg::INDEX_WIDTH-1:0]   out_count_next;

    logic                               start;
    logic                               skip;
    logic [LENGTH_WIDTH-1:0]            bl;
    logic [LENGTH_WIDTH-1:0]            bl1;
    logic [2:0]                         cc0;
    logic [6:0]                         cb0;
    logic [bacs_pkg::INDEX_WIDTH-1:0]   oc0;
    logic [bacs_pkg::INDEX_WIDTH-1:0]   oc1;
    logic [bacs_pkg::INDEX_WIDTH-1:0]   oc2;
    logic [7:0]                         v8;
    logic [7:0]                         vtake;
    logic [3:0]                         avail;
    logic [3:0]                         take;
    logic [14:0]                        cb1;
    logic [14:0]                        cb2;
    logic [4:0]                         cc1;
    logic [4:0]                         cc2;
    logic                               emit1;
    logic                               emit2;
    logic                               done;
    logic [7:0]                         head_mask;
    bacs_pkg::result_t                  r1;
    bacs_pkg::result_t                  r2;

    always_comb
    begin
        start     = !in_transfer_reg;
        skip      = start && (bit_length == '0);
        bl        = start ? bit_length : bits_left_reg;
        cc0       = start ? dst_bit_offset : carry_count_reg;
        cb0       = start ? 7'd0 : carry_bits_reg;
        oc0       = start ? '0 : out_count_reg;
        v8        = start ? 8'(src_byte << src_bit_offset) : src_byte;
        avail     = start ? (4'd8 - {1'b0, src_bit_offset}) : 4'd8;
        take      = (bl < LENGTH_WIDTH'(avail)) ? bl[3:0] : avail;
        vtake     = v8 >> (4'd8 - take);
        cb1       = ({8'd0, cb0} << take) | {7'd0, vtake};
        cc1       = {2'b00, cc0} + {1'b0, take};
        bl1       = bl - LENGTH_WIDTH'(take);
        emit1     = cc1 >= 5'd8;
        cc2       = emit1 ? (cc1 - 5'd8) : cc1;
        cb2       = cb1 & ((15'd1 << cc2) - 15'd1);
        head_mask = bacs_pkg::FULL_MASK >> dst_bit_offset;
        done      = bl1 == '0;
        emit2     = done && (cc2 != 5'd0);
        oc1       = oc0 + bacs_pkg::INDEX_WIDTH'(emit1);
        oc2       = oc1 + bacs_pkg::INDEX_WIDTH'(emit2);

        r1.dst_byte   = 8'(cb1 >> (cc1 - 5'd8));
        r1.write_mask = (oc0 == '0) ? head_mask : bacs_pkg::FULL_MASK;
        r1.dst_index  = oc0;
        r1.last       = done && (cc2 == 5'd0);

        r2.dst_byte   = 8'(cb2 << (5'd8 - cc2));
        r2.write_mask = 8'(bacs_pkg::FULL_MASK << (5'd8 - cc2))
                        & ((oc1 == '0) ? head_mask : bacs_pkg::FULL_MASK);
        r2.dst_index  = oc1;
        r2.last       = 1'b1;
    end

    always_comb
    begin
        push.first  = emit1 ? r1 : r2;
        push.second = r2;
        if (accept && !skip)
        begin
            push.count = {1'b0, emit1} + {1'b0, emit2};
        end
        else
        begin
            push.count = 2'd0;
        end
    end

    always_comb
    begin
        in_transfer_next = in_transfer_reg;
        carry_bits_next  = carry_bits_reg;
        carry_count_next = carry_count_reg;
        bits_left_next   = bits_left_reg;
        out_count_next   = out_count_reg;
        if (accept && !skip)
        begin
            in_transfer_next = !done;
            carry_bits_next  = done ? 7'd0 : cb2[6:0];
            carry_count_next = done ? 3'd0 : cc2[2:0];
            bits_left_next   = bl1;
            out_count_next   = oc2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_transfer_reg <= 1'b0;
            carry_bits_reg  <= '0;
            carry_count_reg <= '0;
            bits_left_reg   <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            in_transfer_reg <= in_transfer_next;
            carry_bits_reg  <= carry_bits_next;
            carry_count_reg <= carry_count_next;
            bits_left_reg   <= bits_left_next;
            out_count_reg   <= out_count_next;
        end
    end

endmodule

`default_nettype wire

[src/bacs_outq.sv]
`default_nettype none

module bacs_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bacs_pkg::push_t   push,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output bacs_pkg::result_t      out_item,
    output logic                   in_ready
);

    localparam int DEPTH = bacs_pkg::QUEUE_DEPTH;
    localparam int CW    = bacs_pkg::COUNT_WIDTH;

    bacs_pkg::result_t q_reg  [DEPTH];
    bacs_pkg::result_t q_next [DEPTH];
    bacs_pkg::result_t sh     [DEPTH];
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [CW-1:0]     base;
    logic              pop;

    assign out_valid = cnt_reg != '0;
    assign out_item  = q_reg[0];
    assign in_ready  = cnt_reg <= CW'(DEPTH - 2);
    assign pop       = out_valid && out_ready;
    assign base      = cnt_reg - CW'(pop);
    assign cnt_next  = base + CW'(push.count);

    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            sh[i] = q_reg[i + 1];
        end
        sh[DEPTH-1] = q_reg[DEPTH-1];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CW'(i) < base)
            begin
                q_next[i] = pop ? sh[i] : q_reg[i];
            end
            else if ((CW'(i) == base) && (push.count != 2'd0))
            begin
                q_next[i] = push.first;
            end
            else if ((CW'(i) == base + CW'(1)) && (push.count == 2'd2))
            begin
                q_next[i] = push.second;
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

`default_nettype wire

[src/bit_aligned_copy_stream.sv]
// results of an accepted source byte are registered in the result queue before they reach the m_ side
// throughput: one source byte per cycle while s_tready is high; the final byte of a transfer may give two results
// s_tready drops while the four-entry result queue holds more than two results
// reset: rst_n asynchronous active low, clears configuration, carry state and queue
`default_nettype none

module bit_aligned_copy_stream #(
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bacs_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [bacs_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic      [bacs_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // src_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [31:0]                       m_tdata,  // dst_byte, write_mask, dst_index
    output logic                                   m_tlast
);

    logic [2:0]              src_bit_offset_reg;
    logic [2:0]              dst_bit_offset_reg;
    logic [LENGTH_WIDTH-1:0] bit_length_reg;
    logic                    wr_en;
    bacs_pkg::reg_index_t    reg_index;
    logic                    accept;
    bacs_pkg::push_t         push;
    bacs_pkg::result_t       item;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = bacs_pkg::reg_index_t'(paddr[3:2]);
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        case (reg_index)
            bacs_pkg::REG_SRC_BIT_OFFSET: prdata = {29'd0, src_bit_offset_reg};
            bacs_pkg::REG_DST_BIT_OFFSET: prdata = {29'd0, dst_bit_offset_reg};
            bacs_pkg::REG_BIT_LENGTH:     prdata = bacs_pkg::DATA_WIDTH'(bit_length_reg);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_bit_offset_reg <= '0;
            dst_bit_offset_reg <= '0;
            bit_length_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                bacs_pkg::REG_SRC_BIT_OFFSET: src_bit_offset_reg <= pwdata[2:0];
                bacs_pkg::REG_DST_BIT_OFFSET: dst_bit_offset_reg <= pwdata[2:0];
                bacs_pkg::REG_BIT_LENGTH:     bit_length_reg     <= pwdata[LENGTH_WIDTH-1:0];
                default:                      ;
            endcase
        end
    end

    bacs_align #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_align (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .src_byte      (s_tdata),
        .src_bit_offset(src_bit_offset_reg),
        .dst_bit_offset(dst_bit_offset_reg),
        .bit_length    (bit_length_reg),
        .push          (push)
    );

    bacs_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_item (item),
        .in_ready (s_tready)
    );

    assign m_tdata = {2'b00, item.dst_index, item.write_mask, item.dst_byte};
    assign m_tlast = item.last;

endmodule

`default_nettype wire

[bench/bacs_checker.sv]
`default_nettype none

module bacs_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [bacs_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [bacs_pkg::DATA_WIDTH-1:0] pwdata,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [31:0]                     m_tdata,
    input  wire logic                            m_tlast,
    output int                                   errors,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]                       src_off;
    logic [2:0]                       dst_off;
    logic [15:0]                      copy_len;
    logic [15:0]                      carry_bits;
    logic [4:0]                       carry_count;
    logic [16:0]                      bits_left;
    logic [bacs_pkg::INDEX_WIDTH-1:0] dst_count;
    logic                             copy_open;
    bacs_pkg::result_t                dst_writes_due[$];

    task automatic report(input string field, input int unsigned want, input int unsigned got);
        $display("%0t ns: mismatch on %s, expected %0h got %0h", $time, field, want, got);
        errors++;
    endtask

    function automatic void emit_dst_byte(logic [7:0] data, logic [7:0] mask, logic is_last);
        bacs_pkg::result_t r;
        r.dst_byte   = data;
        r.write_mask = mask;
        r.dst_index  = dst_count;
        r.last       = is_last;
        dst_writes_due.push_back(r);
        dst_count = dst_count + 1'b1;
    endfunction

    function automatic void realign_src_byte(logic [7:0] sb);
        int         avail;
        int         take;
        int         v;
        logic [7:0] mask;
        bit         opening;
        opening = 1'b0;
        if (!copy_open)
        begin
            if (copy_len == 0)
                return;
            bits_left   = 17'(copy_len);
            carry_bits  = '0;
            carry_count = 5'(dst_off);
            dst_count   = '0;
            copy_open   = 1'b1;
            opening     = 1'b1;
        end
        // drop the bits ahead of the run on the opening byte
        if (opening)
        begin
            v     = (int'(sb) << src_off) & 'hff;
            avail = 8 - int'(src_off);
        end
        else
        begin
            v     = int'(sb);
            avail = 8;
        end
        take = (bits_left < avail) ? int'(bits_left) : avail;
        v    = v >> (8 - take);
        carry_bits  = 16'((int'(carry_bits) << take) | v);
        carry_count = carry_count + 5'(take);
        bits_left   = bits_left - 17'(take);
        while (carry_count >= 8)
        begin
            mask = (dst_count == 0) ? (bacs_pkg::FULL_MASK >> dst_off) : bacs_pkg::FULL_MASK;
            carry_count = carry_count - 5'd8;
            emit_dst_byte(8'(carry_bits >> carry_count), mask,
                          bits_left == 0 && carry_count == 0);
            carry_bits = carry_bits & ((16'd1 << carry_count) - 16'd1);
        end
        if (bits_left == 0)
        begin
            if (carry_count > 0)
            begin
                mask = bacs_pkg::FULL_MASK << (8 - carry_count);
                if (dst_count == 0)
                    mask = mask & (bacs_pkg::FULL_MASK >> dst_off);
                emit_dst_byte(8'(carry_bits << (8 - carry_count)), mask, 1'b1);
            end
            carry_bits  = '0;
            carry_count = '0;
            copy_open   = 1'b0;
        end
    endfunction

    task automatic check_dst_write();
        bacs_pkg::result_t want;
        if (dst_writes_due.size() == 0)
        begin
            report("transfer with nothing due", 0, m_tdata);
            return;
        end
        want = dst_writes_due.pop_front();
        if (m_tdata[7:0] != want.dst_byte)
            report("dst_byte", 32'(want.dst_byte), 32'(m_tdata[7:0]));
        if (m_tdata[15:8] != want.write_mask)
            report("write_mask", 32'(want.write_mask), 32'(m_tdata[15:8]));
        if (m_tdata[16 +: bacs_pkg::INDEX_WIDTH] != want.dst_index)
            report("dst_index", 32'(want.dst_index),
                   32'(m_tdata[16 +: bacs_pkg::INDEX_WIDTH]));
        if (m_tlast != want.last)
            report("last", 32'(want.last), 32'(m_tlast));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_off     = '0;
            dst_off     = '0;
            copy_len    = '0;
            carry_bits  = '0;
            carry_count = '0;
            bits_left   = '0;
            dst_count   = '0;
            copy_open   = 1'b0;
            dst_writes_due.delete();
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_dst_write();
            if (s_tvalid && s_tready)
                realign_src_byte(s_tdata);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[bacs_pkg::ADDR_WIDTH-1:2])
                    bacs_pkg::REG_SRC_BIT_OFFSET: src_off  = pwdata[2:0];
                    bacs_pkg::REG_DST_BIT_OFFSET: dst_off  = pwdata[2:0];
                    bacs_pkg::REG_BIT_LENGTH:     copy_len = pwdata[15:0];
                    default:                      ;
                endcase
            end
            pending = dst_writes_due.size();
        end
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bacs_pkg::ADDR_WIDTH-1:0] ADDR_UNUSED = 4'd12;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bacs_pkg::ADDR_WIDTH-1:0] paddr;
    logic [bacs_pkg::DATA_WIDTH-1:0] pwdata;
    wire  [bacs_pkg::DATA_WIDTH-1:0] prdata;
    wire                             pready;
    logic                            s_tvalid;
    wire                             s_tready;
    logic [7:0]                      s_tdata;
    wire                             m_tvalid;
    logic                            m_tready = 1'b0;
    wire  [31:0]                     m_tdata;
    wire                             m_tlast;
    int                              errors;
    int                              pending;

    int                              burst_left = 0;
    int                              rx_tick = 0;
    int                              rx_mode = 0;
    int                              random_bytes;

    bit_aligned_copy_stream u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bacs_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver back-pressure, changing its pattern now and then
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 128 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 4) != 0);
            default: m_tready <= (rx_tick % 8) >= 5;
        endcase
    end

    task automatic apb_write(input logic [bacs_pkg::ADDR_WIDTH-1:0] addr,
                             input logic [bacs_pkg::DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        burst_left--;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_copy(input int src, input int dst, input int len);
        wait_drained();
        apb_write({bacs_pkg::REG_SRC_BIT_OFFSET, 2'b00}, ($urandom() & ~32'h7) | src);
        apb_write({bacs_pkg::REG_DST_BIT_OFFSET, 2'b00}, ($urandom() & ~32'h7) | dst);
        apb_write({bacs_pkg::REG_BIT_LENGTH, 2'b00}, ($urandom() & ~32'hffff) | len);
    endtask

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int src;
        int dst;
        int len;
        int sel;
        int per_copy;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero length after reset, and a write outside the register map
        apb_write(ADDR_UNUSED, 32'hffff_ffff);
        send_byte(8'hff);
        send_byte(8'h00);

        set_copy(0, 0, 8);
        send_byte(8'hff);
        send_byte(8'h00);
        set_copy(7, 7, 1);
        send_byte(8'h01);
        send_byte(8'hfe);
        set_copy(0, 7, 16);
        send_byte(8'ha5);
        send_byte(8'h5a);
        set_copy(7, 0, 2);
        send_byte(8'h80);
        send_byte(8'h80);

        // destination offset and length rewritten while a copy is open
        set_copy(3, 0, 40);
        send_byte(8'h3c);
        wait_drained();
        apb_write({bacs_pkg::REG_DST_BIT_OFFSET, 2'b00}, 32'd5);
        apb_write({bacs_pkg::REG_BIT_LENGTH, 2'b00}, 32'd9);
        send_byte(8'hc3);
        send_byte(8'h81);
        send_byte(8'h7e);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h96);
        send_byte(8'h69);

        random_bytes = 0;
        while (random_bytes < 900)
        begin
            src = $urandom_range(0, 7);
            dst = $urandom_range(0, 7);
            sel = $urandom_range(0, 19);
            if (sel == 0)
                len = 0;
            else if (sel == 1)
                len = $urandom_range(100, 600);
            else if (sel < 6)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(1, 48);
            set_copy(src, dst, len);
            if ($urandom_range(0, 9) == 0)
                apb_write(ADDR_UNUSED, $urandom());
            if (len == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                per_copy = (src + len + 7) / 8;
                repeat ($urandom_range(1, 4) * per_copy)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                    random_bytes++;
                    if ($urandom_range(0, 49) == 0)
                        wait_drained();
                end
            end
        end

        // a long run across many destination bytes
        set_copy(7, 7, 1500);
        repeat ((7 + 1500 + 7) / 8)
            send_byte(8'($urandom_range(0, 255)));

        set_copy(0, 0, 0);
        wait_drained();
        repeat (10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
